/* src/cepsolv_pkg.sv */
// shared types, widths and constants of the cherenkov emission point solver
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package cepsolv_pkg;

  // default for the coordinate width parameter of the top level
  localparam int COORD_WIDTH_DEF = 32;

  // port field widths
  localparam int POS_W     = 32;
  localparam int DIR_W     = 18;
  localparam int STAMP_W   = 32;
  localparam int INV_W     = 17;
  localparam int LS_W      = 25;
  localparam int ROOT_W    = 40;
  localparam int CNT_OUT_W = 2;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // fraction bits of the fixed-point scalings
  localparam int FRAC_W = 16;

  // internal datapath widths, sized to the value ranges
  localparam int R_W   = 33;  // hit minus entry
  localparam int T_W   = 33;  // hit time minus entry time
  localparam int SUM_W = 52;  // sum of r.dir products
  localparam int D_W   = 43;  // light path length
  localparam int KD_W  = 44;  // k times path length
  localparam int H_W   = 45;  // half of b
  localparam int RSQ_W = 67;  // |r|^2, unsigned
  localparam int C_W   = 86;  // c term
  localparam int HH_W  = 87;  // h^2, unsigned
  localparam int Q_W   = 88;  // quarter discriminant
  localparam int A_W   = 18;  // a term in q.16

  // shared multiplier: one 8-bit digit of y per cycle
  localparam int X_W        = 86;
  localparam int Y_W        = 48;
  localparam int MUL_DIG_W  = 8;
  localparam int MUL_DIGITS = Y_W / MUL_DIG_W;
  localparam int P_W        = 102;
  localparam int PS_W       = P_W + 1;

  // shared square root / divide unit: one result bit per cycle
  localparam int RAD_W      = 88;
  localparam int SQRT_ITERS = RAD_W / 2;
  localparam int S_W        = 44;
  localparam int NUM_W      = 47;
  localparam int DVD_W      = 62;
  localparam int DIV_ITERS  = DVD_W;
  localparam int DEN_W      = 17;
  localparam int REM_W      = 48;

  // register reset values
  localparam logic [INV_W-1:0] INV_RESET = 17'd37049;
  localparam logic [LS_W-1:0]  LS_RESET  = 25'd19647352;
  localparam logic [A_W-1:0]   ONE_Q16   = 18'd65536;

  // root saturation limits
  localparam logic signed [ROOT_W-1:0] ROOT_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [ROOT_W-1:0] ROOT_MIN = 40'sh80_0000_0000;

  // root counts
  localparam logic [CNT_OUT_W-1:0] COUNT_NONE = 2'd0;
  localparam logic [CNT_OUT_W-1:0] COUNT_ONE  = 2'd1;
  localparam logic [CNT_OUT_W-1:0] COUNT_TWO  = 2'd2;

  typedef enum logic {
    CMD_TRACK = 1'b0,
    CMD_HIT   = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_INV_INDEX_SQ = 1'b0,
    REG_LIGHT_SPEED  = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_CLASSIFY,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  // order of the multiplications of one hit
  typedef enum logic [3:0] {
    MS_RD0,
    MS_RD1,
    MS_RD2,
    MS_RR0,
    MS_RR1,
    MS_RR2,
    MS_LD,
    MS_KD,
    MS_KDD,
    MS_HH,
    MS_AC
  } mstep_t;

  typedef enum logic {
    DS_SQRT = 1'b0,
    DS_DIV  = 1'b1
  } ds_mode_t;

  typedef struct packed {
    logic           start;
    logic           neg;
    logic [X_W-1:0] x_mag;
    logic [Y_W-1:0] y_mag;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    ds_mode_t         mode;
    logic [RAD_W-1:0] radicand;
    logic [DVD_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } ds_req_t;

endpackage

/* src/cherenkov_emission_point_solver_core.sv */
// cherenkov emission point solver: sequencer, track store, config port, result register
// depends on cepsolv_pkg, cepsolv_mul and cepsolv_dsq
// track transaction: stored in the track store, no result
// hit transaction: eleven multiplies on the 8-bit-digit shared multiplier, then,
//   with a real root, the 1-bit-per-cycle square root and divide unit; not ready
//   while a hit is in work
// synchronous active-low reset: track store cleared, registers to defaults
`timescale 1ns / 1ps

module cherenkov_emission_point_solver_core import cepsolv_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic signed [POS_W-1:0]     in_pos_x,
  input  logic signed [POS_W-1:0]     in_pos_y,
  input  logic signed [POS_W-1:0]     in_pos_z,
  input  logic signed [DIR_W-1:0]     in_dir_x,
  input  logic signed [DIR_W-1:0]     in_dir_y,
  input  logic signed [DIR_W-1:0]     in_dir_z,
  input  logic signed [STAMP_W-1:0]   in_stamp,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [CNT_OUT_W-1:0]        out_root_count,
  output logic signed [ROOT_W-1:0]    out_root_plus,
  output logic signed [ROOT_W-1:0]    out_root_minus,
  output logic                        out_overflow,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_AW-1:0]           paddr,
  input  logic [APB_DW-1:0]           pwdata,
  output logic [APB_DW-1:0]           prdata,
  output logic                        pready
);

  localparam int PosBits  = (COORD_WIDTH < POS_W) ? COORD_WIDTH : POS_W;
  localparam int PosShift = POS_W - PosBits;

  // configuration registers
  logic [INV_W-1:0] inv_r;
  logic [LS_W-1:0]  ls_r;

  // track store
  logic signed [POS_W-1:0]   track_start_r [3];
  logic signed [DIR_W-1:0]   track_dir_r [3];
  logic signed [STAMP_W-1:0] track_time_r;

  // hit working registers
  state_t                  state_r, state_nxt;
  mstep_t                  step_r;
  logic signed [R_W-1:0]   r_r [3];
  logic signed [T_W-1:0]   dt_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [RSQ_W-1:0]        rsq_r;
  logic signed [D_W-1:0]   d_r;
  logic signed [KD_W-1:0]  kd_r;
  logic signed [H_W-1:0]   h_r;
  logic signed [C_W-1:0]   c_r;
  logic [HH_W-1:0]         hh_r;
  logic signed [Q_W-1:0]   q_r;
  logic [S_W-1:0]          s_r;
  logic                    root_sel_r;
  logic [CNT_OUT_W-1:0]    count_r;
  logic signed [ROOT_W-1:0] rp_r;
  logic signed [ROOT_W-1:0] rm_r;
  logic                    ov_r;

  // result register
  logic                     out_valid_r;
  logic [CNT_OUT_W-1:0]     out_count_r;
  logic signed [ROOT_W-1:0] out_plus_r;
  logic signed [ROOT_W-1:0] out_minus_r;
  logic                     out_ov_r;

  // unit interfaces
  mul_req_t               mul_req;
  logic                   mul_done;
  logic signed [PS_W-1:0] prod;
  ds_req_t                ds_req;
  logic                   ds_done;
  logic [DVD_W-1:0]       ds_result;
  logic                   mul_start;
  logic                   ds_start;
  ds_mode_t               ds_mode;

  logic                    in_take;
  logic                    cfg_wr;
  logic signed [POS_W-1:0] pos_in [3];
  logic signed [DIR_W-1:0] dir_in [3];
  logic [R_W-1:0]          r_abs [3];
  logic [DIR_W-1:0]        dir_abs [3];
  logic [T_W-1:0]          dt_abs;
  logic [D_W-1:0]          d_abs;
  logic [KD_W-1:0]         kd_abs;
  logic [H_W-1:0]          h_abs;
  logic [C_W-1:0]          c_abs;
  logic [A_W-1:0]          a_abs;
  logic signed [A_W-1:0]   a_val;
  logic                    a_zero;
  logic signed [KD_W-1:0]  kd_new;
  logic                    q_neg;
  logic                    q_zero;
  logic [1:0]              mul_idx;
  logic signed [NUM_W-1:0] h_ext;
  logic signed [NUM_W-1:0] s_ext;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_abs;
  logic signed [DVD_W:0]   quo_s;
  logic signed [ROOT_W-1:0] root_val;
  logic                    root_ov;
  logic                    root_wr;
  logic                    out_free;
  state_t                  root_next;

  cepsolv_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (prod)
  );

  cepsolv_dsq u_dsq (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ds_req),
    .done   (ds_done),
    .result (ds_result)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_INV_INDEX_SQ: prdata = APB_DW'(inv_r);
      REG_LIGHT_SPEED:  prdata = APB_DW'(ls_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= INV_RESET;
      ls_r  <= LS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_INV_INDEX_SQ: inv_r <= pwdata[INV_W-1:0];
        REG_LIGHT_SPEED:  ls_r  <= pwdata[LS_W-1:0];
        default: ;
      endcase
    end
  end

  // input decode, positions cut to the coordinate width
  always_comb begin
    pos_in[0] = (in_pos_x <<< PosShift) >>> PosShift;
    pos_in[1] = (in_pos_y <<< PosShift) >>> PosShift;
    pos_in[2] = (in_pos_z <<< PosShift) >>> PosShift;
    dir_in[0] = in_dir_x;
    dir_in[1] = in_dir_y;
    dir_in[2] = in_dir_z;
  end

  assign in_take = in_valid & in_ready;

  // magnitudes and derived terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_abs[i]   = r_r[i][R_W-1] ? R_W'(-r_r[i]) : R_W'(r_r[i]);
      dir_abs[i] = track_dir_r[i][DIR_W-1] ? DIR_W'(-track_dir_r[i]) : DIR_W'(track_dir_r[i]);
    end
    dt_abs  = dt_r[T_W-1] ? T_W'(-dt_r) : T_W'(dt_r);
    d_abs   = d_r[D_W-1] ? D_W'(-d_r) : D_W'(d_r);
    kd_abs  = kd_r[KD_W-1] ? KD_W'(-kd_r) : KD_W'(kd_r);
    h_abs   = h_r[H_W-1] ? H_W'(-h_r) : H_W'(h_r);
    c_abs   = c_r[C_W-1] ? C_W'(-c_r) : C_W'(c_r);
    a_val   = $signed(A_W'(inv_r)) - $signed(ONE_Q16);
    a_zero  = (A_W'(inv_r) == ONE_Q16);
    a_abs   = a_val[A_W-1] ? A_W'(-a_val) : A_W'(a_val);
    kd_new  = KD_W'(prod >>> FRAC_W);
    q_neg   = q_r[Q_W-1];
    q_zero  = (q_r == '0);
  end

  // multiplier operands for each step
  always_comb begin
    mul_req.start = mul_start;
    mul_req.x_mag = '0;
    mul_req.y_mag = '0;
    mul_req.neg   = 1'b0;
    mul_idx       = '0;
    case (step_r)
      MS_RD0, MS_RD1, MS_RD2: begin
        mul_idx       = 2'(step_r - MS_RD0);
        mul_req.x_mag = X_W'(r_abs[mul_idx]);
        mul_req.y_mag = Y_W'(dir_abs[mul_idx]);
        mul_req.neg   = r_r[mul_idx][R_W-1] ^ track_dir_r[mul_idx][DIR_W-1];
      end
      MS_RR0, MS_RR1, MS_RR2: begin
        mul_idx       = 2'(step_r - MS_RR0);
        mul_req.x_mag = X_W'(r_abs[mul_idx]);
        mul_req.y_mag = Y_W'(r_abs[mul_idx]);
      end
      MS_LD: begin
        mul_req.x_mag = X_W'(dt_abs);
        mul_req.y_mag = Y_W'(ls_r);
        mul_req.neg   = dt_r[T_W-1];
      end
      MS_KD: begin
        mul_req.x_mag = X_W'(d_abs);
        mul_req.y_mag = Y_W'(inv_r);
        mul_req.neg   = d_r[D_W-1];
      end
      MS_KDD: begin
        mul_req.x_mag = X_W'(kd_abs);
        mul_req.y_mag = Y_W'(d_abs);
        mul_req.neg   = kd_r[KD_W-1] ^ d_r[D_W-1];
      end
      MS_HH: begin
        mul_req.x_mag = X_W'(h_abs);
        mul_req.y_mag = Y_W'(h_abs);
      end
      MS_AC: begin
        mul_req.x_mag = X_W'(c_abs);
        mul_req.y_mag = Y_W'(a_abs);
        mul_req.neg   = c_r[C_W-1] ^ a_val[A_W-1];
      end
      default: ;
    endcase
  end

  // root numerator and divider operands
  always_comb begin
    h_ext    = NUM_W'(h_r);
    s_ext    = $signed(NUM_W'(s_r));
    num      = root_sel_r ? (-h_ext - s_ext) : (s_ext - h_ext);
    num_abs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    ds_req.start    = ds_start;
    ds_req.mode     = ds_mode;
    ds_req.radicand = RAD_W'(q_r);
    ds_req.dividend = DVD_W'({num_abs, FRAC_W'(0)});
    ds_req.divisor  = DEN_W'(a_abs);
  end

  // root value: saturate on zero a, else signed quotient clamped
  always_comb begin
    quo_s    = (num[NUM_W-1] ^ a_val[A_W-1]) ? -$signed({1'b0, ds_result})
                                              : $signed({1'b0, ds_result});
    root_val = ROOT_W'(quo_s);
    root_ov  = 1'b0;
    if (a_zero) begin
      root_ov = 1'b1;
      if (num == '0) begin
        root_val = '0;
      end else if (num[NUM_W-1]) begin
        root_val = ROOT_MIN;
      end else begin
        root_val = ROOT_MAX;
      end
    end else if (quo_s > (DVD_W+1)'(ROOT_MAX)) begin
      root_val = ROOT_MAX;
      root_ov  = 1'b1;
    end else if (quo_s < (DVD_W+1)'(ROOT_MIN)) begin
      root_val = ROOT_MIN;
      root_ov  = 1'b1;
    end
  end

  // next state
  always_comb begin
    root_next = (count_r == COUNT_TWO && !root_sel_r) ? ST_DIV_GO : ST_FINISH;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && cmd_t'(in_cmd) == CMD_HIT) state_nxt = ST_MUL_GO;
      end
      ST_MUL_GO:   state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) state_nxt = (step_r == MS_AC) ? ST_CLASSIFY : ST_MUL_GO;
      end
      ST_CLASSIFY: begin
        if (q_neg) begin
          state_nxt = ST_FINISH;
        end else if (q_zero) begin
          state_nxt = ST_DIV_GO;
        end else begin
          state_nxt = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (ds_done) state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO:   state_nxt = a_zero ? root_next : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (ds_done) state_nxt = root_next;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    ds_start  = 1'b0;
    ds_mode   = DS_DIV;
    root_wr   = 1'b0;
    case (state_r)
      ST_IDLE:    in_ready = 1'b1;
      ST_MUL_GO:  mul_start = 1'b1;
      ST_SQRT_GO: begin
        ds_start = 1'b1;
        ds_mode  = DS_SQRT;
      end
      ST_DIV_GO: begin
        ds_start = ~a_zero;
        root_wr  = a_zero;
      end
      ST_DIV_WAIT: root_wr = ds_done;
      default: ;
    endcase
  end

  assign out_free = ~out_valid_r | out_ready;

  // sequencer and track store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= MS_RD0;
      root_sel_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        track_start_r[i] <= '0;
        track_dir_r[i]   <= '0;
      end
      track_time_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_take && cmd_t'(in_cmd) == CMD_TRACK) begin
        for (int i = 0; i < 3; i++) begin
          track_start_r[i] <= pos_in[i];
          track_dir_r[i]   <= dir_in[i];
        end
        track_time_r <= in_stamp;
      end
      if (in_take) begin
        step_r     <= MS_RD0;
        root_sel_r <= 1'b0;
      end else if (state_r == ST_MUL_WAIT && mul_done && step_r != MS_AC) begin
        step_r <= mstep_t'(step_r + 1'b1);
      end
      if (root_wr) root_sel_r <= 1'b1;
    end
  end

  // hit datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < 3; i++) begin
        r_r[i] <= R_W'(pos_in[i]) - R_W'(track_start_r[i]);
      end
      dt_r    <= T_W'(in_stamp) - T_W'(track_time_r);
      sum_r   <= '0;
      rsq_r   <= '0;
      s_r     <= '0;
      rp_r    <= '0;
      rm_r    <= '0;
      count_r <= COUNT_NONE;
      ov_r    <= 1'b0;
    end
    // fold each product into its term
    if (state_r == ST_MUL_WAIT && mul_done) begin
      case (step_r)
        MS_RD0, MS_RD1, MS_RD2: sum_r <= sum_r + SUM_W'(prod);
        MS_RR0, MS_RR1, MS_RR2: rsq_r <= rsq_r + RSQ_W'(prod);
        MS_LD:  d_r <= D_W'(prod >>> FRAC_W);
        MS_KD: begin
          kd_r <= kd_new;
          h_r  <= H_W'(sum_r >>> FRAC_W) - H_W'(kd_new);
        end
        MS_KDD: c_r  <= C_W'(prod) - C_W'(rsq_r);
        MS_HH:  hh_r <= HH_W'(prod);
        MS_AC:  q_r  <= Q_W'(hh_r) - Q_W'(prod >>> FRAC_W);
        default: ;
      endcase
    end
    // root count from the sign of the discriminant
    if (state_r == ST_CLASSIFY) begin
      ov_r <= a_zero;
      if (q_neg) begin
        count_r <= COUNT_NONE;
      end else if (q_zero) begin
        count_r <= COUNT_ONE;
      end else begin
        count_r <= COUNT_TWO;
      end
    end
    if (state_r == ST_SQRT_WAIT && ds_done) s_r <= ds_result[S_W-1:0];
    // store a finished root
    if (root_wr) begin
      if (root_sel_r) begin
        rm_r <= root_val;
      end else begin
        rp_r <= root_val;
      end
      if (root_ov) ov_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) begin
      out_count_r <= count_r;
      out_plus_r  <= rp_r;
      out_minus_r <= rm_r;
      out_ov_r    <= ov_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_root_count = out_count_r;
  assign out_root_plus  = out_plus_r;
  assign out_root_minus = out_minus_r;
  assign out_overflow   = out_ov_r;

  // after a track transaction the input is ready again
  a_track_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_cmd |=> in_ready)
    else $error("track transaction did not return to idle");

  // a hit transaction blocks the input until done
  a_hit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd |=> !in_ready)
    else $error("input ready while a hit is in work");

  // roots not returned read as zero
  a_unused_roots_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_count == COUNT_NONE |-> out_root_plus == '0 && out_root_minus == '0)
    else $error("root given with zero count");

  a_minus_only_with_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_count != COUNT_TWO |-> out_root_minus == '0)
    else $error("minus root given without two roots");

  // the two shared units never finish together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && ds_done))
    else $error("multiplier and root unit finished together");

endmodule

/* src/cepsolv_mul.sv */
// shared sign-magnitude multiplier, one 8-bit digit of y per cycle
// depends on cepsolv_pkg
`timescale 1ns / 1ps

module cepsolv_mul import cepsolv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mul_req_t               req,
  output logic                   done,
  output logic signed [PS_W-1:0] prod
);

  localparam int CntW = $clog2(MUL_DIGITS);
  localparam logic [CntW-1:0] CntLast = CntW'(MUL_DIGITS - 1);

  logic            busy_r;
  logic            done_r;
  logic [CntW-1:0] cnt_r;
  logic [P_W-1:0]  xs_r;
  logic [Y_W-1:0]  ys_r;
  logic [P_W-1:0]  acc_r;
  logic            neg_r;
  logic [P_W+MUL_DIG_W-1:0] pp;
  logic [P_W-1:0]  acc_nxt;

  // one partial product per cycle
  always_comb begin
    pp      = xs_r * ys_r[MUL_DIG_W-1:0];
    acc_nxt = acc_r + pp[P_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntLast) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      xs_r  <= P_W'(req.x_mag);
      ys_r  <= req.y_mag;
      acc_r <= '0;
      neg_r <= req.neg;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      xs_r  <= xs_r << MUL_DIG_W;
      ys_r  <= ys_r >> MUL_DIG_W;
    end
  end

  // apply the sign
  always_comb begin
    prod = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
  end

  assign done = done_r;

endmodule

/* src/cepsolv_dsq.sv */
// shared restoring square root and divide unit, one result bit per cycle
// depends on cepsolv_pkg
`timescale 1ns / 1ps

module cepsolv_dsq import cepsolv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ds_req_t          req,
  output logic             done,
  output logic [DVD_W-1:0] result
);

  localparam int CntW = $clog2(DIV_ITERS);

  logic             busy_r;
  logic             done_r;
  ds_mode_t         mode_r;
  logic [CntW-1:0]  cnt_r;
  logic [RAD_W-1:0] acc_r;
  logic [REM_W-1:0] rem_r;
  logic [DVD_W-1:0] res_r;
  logic [DEN_W-1:0] den_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [RAD_W-1:0] acc_nxt;
  logic [REM_W:0]   diff;
  logic             fits;
  logic             last;

  // operand selection and the shared subtractor
  always_comb begin
    if (mode_r == DS_SQRT) begin
      rem_sh  = {rem_r[REM_W-3:0], acc_r[RAD_W-1 -: 2]};
      trial   = {res_r[REM_W-3:0], 2'b01};
      acc_nxt = acc_r << 2;
      last    = (cnt_r == CntW'(SQRT_ITERS - 1));
    end else begin
      rem_sh  = {rem_r[REM_W-2:0], acc_r[RAD_W-1]};
      trial   = REM_W'(den_r);
      acc_nxt = acc_r << 1;
      last    = (cnt_r == CntW'(DIV_ITERS - 1));
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    fits = ~diff[REM_W];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.mode;
      den_r  <= req.divisor;
      rem_r  <= '0;
      res_r  <= '0;
      if (req.mode == DS_SQRT) begin
        acc_r <= req.radicand;
      end else begin
        acc_r <= {req.dividend, (RAD_W - DVD_W)'(0)};
      end
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= fits ? diff[REM_W-1:0] : rem_sh;
      res_r <= {res_r[DVD_W-2:0], fits};
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

/* sim/cherenkov_emission_point_solver_core_tb.sv */
// self-checking testbench for cherenkov_emission_point_solver_core
// depends on cepsolv_pkg and the solver rtl; predicts emission roots in wide integer math
`timescale 1ns / 1ps

module cherenkov_emission_point_solver_core_tb;
  import cepsolv_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    cmd_t                      cmd;
    logic signed [POS_W-1:0]   px, py, pz;
    logic signed [DIR_W-1:0]   dx, dy, dz;
    logic signed [STAMP_W-1:0] stamp;
  } hit_item_t;

  typedef struct {
    logic [CNT_OUT_W-1:0]     cnt;
    logic signed [ROOT_W-1:0] plus;
    logic signed [ROOT_W-1:0] minus;
    logic                     ov;
  } roots_t;

  localparam int SETTLE_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [DIR_W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [STAMP_W-1:0] in_stamp = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CNT_OUT_W-1:0] out_root_count;
  logic signed [ROOT_W-1:0] out_root_plus, out_root_minus;
  logic out_overflow;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  cherenkov_emission_point_solver_core uut (.*);

  always #10 clk = ~clk;

  // queues of stimulus and of predicted roots
  hit_item_t pending_hits[$];
  roots_t    expected_roots[$];
  int        fail_count = 0;
  longint    cycle_count = 0;

  // shadow of the track store and registers
  longint trk_x, trk_y, trk_z, trk_dx, trk_dy, trk_dz, trk_t;
  longint k_q16 = longint'(INV_RESET);
  longint c_q16 = longint'(LS_RESET);
  longint gen_t0 = 0;

  // one root: numerator over a, saturated to the root range
  function automatic longint root_div(longint num, longint a, inout bit ov);
    longint q;
    if (a == 0) begin
      ov = 1'b1;
      return (num > 0) ? longint'(ROOT_MAX) : ((num < 0) ? longint'(ROOT_MIN) : 0);
    end
    q = (num * 65536) / a;
    if (q > longint'(ROOT_MAX)) begin
      ov = 1'b1;
      return longint'(ROOT_MAX);
    end
    if (q < longint'(ROOT_MIN)) begin
      ov = 1'b1;
      return longint'(ROOT_MIN);
    end
    return q;
  endfunction

  // apply one accepted transaction to the shadow state, queue roots for hits
  function automatic void solve_emission(hit_item_t it);
    longint rx, ry, rz, u, dt, d, kd, h, a, rp, rm, s;
    wide_t rsq, c, q;
    logic [127:0] qu, sq;
    logic [63:0] sr, cand;
    bit ov;
    roots_t res;
    if (it.cmd == CMD_TRACK) begin
      trk_x = it.px; trk_y = it.py; trk_z = it.pz;
      trk_dx = it.dx; trk_dy = it.dy; trk_dz = it.dz;
      trk_t = it.stamp;
      return;
    end
    rx = longint'(it.px) - trk_x;
    ry = longint'(it.py) - trk_y;
    rz = longint'(it.pz) - trk_z;
    u = (rx * trk_dx + ry * trk_dy + rz * trk_dz) >>> 16;
    dt = longint'(it.stamp) - trk_t;
    d = (c_q16 * dt) >>> 16;
    kd = (k_q16 * d) >>> 16;
    h = u - kd;
    a = k_q16 - 65536;
    rsq = wide_t'(rx) * wide_t'(rx) + wide_t'(ry) * wide_t'(ry) + wide_t'(rz) * wide_t'(rz);
    c = wide_t'(kd) * wide_t'(d) - rsq;
    q = wide_t'(h) * wide_t'(h) - ((c * wide_t'(a)) >>> 16);
    ov = (a == 0);
    rp = 0;
    rm = 0;
    if (q < 0) begin
      res.cnt = COUNT_NONE;
    end else if (q == 0) begin
      res.cnt = COUNT_ONE;
      rp = root_div(-h, a, ov);
    end else begin
      // bitwise floor square root
      qu = q;
      sr = '0;
      for (int i = 63; i >= 0; i--) begin
        cand = sr | (64'd1 << i);
        sq = {64'd0, cand} * {64'd0, cand};
        if (sq <= qu) sr = cand;
      end
      s = longint'(sr);
      res.cnt = COUNT_TWO;
      rp = root_div(-h + s, a, ov);
      rm = root_div(-h - s, a, ov);
    end
    res.plus = rp[ROOT_W-1:0];
    res.minus = rm[ROOT_W-1:0];
    res.ov = ov;
    expected_roots = {expected_roots, res};
  endfunction

  // input driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic fire, busy;
    hit_item_t nxt;
    fire = in_valid && in_ready;
    busy = in_valid && !fire;
    if (fire) begin
      nxt.cmd = cmd_t'(in_cmd);
      nxt.px = in_pos_x; nxt.py = in_pos_y; nxt.pz = in_pos_z;
      nxt.dx = in_dir_x; nxt.dy = in_dir_y; nxt.dz = in_dir_z;
      nxt.stamp = in_stamp;
      solve_emission(nxt);
    end
    if (rst_n && !busy) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_hits.size() > 0) begin
        nxt = pending_hits.pop_front();
        in_valid <= 1'b1;
        in_cmd <= nxt.cmd;
        in_pos_x <= nxt.px; in_pos_y <= nxt.py; in_pos_z <= nxt.pz;
        in_dir_x <= nxt.dx; in_dir_y <= nxt.dy; in_dir_z <= nxt.dz;
        in_stamp <= nxt.stamp;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor with its own stall pattern
  int stall_left = 0;
  int run_left = 0;
  always @(posedge clk) begin
    roots_t exp_r;
    if (out_valid && out_ready) begin
      if (expected_roots.size() == 0) begin
        $error("unexpected result transaction: count %0d", out_root_count);
        fail_count++;
      end else begin
        exp_r = expected_roots.pop_front();
        if (out_root_count !== exp_r.cnt) begin
          $error("root_count expected %0d actual %0d", exp_r.cnt, out_root_count);
          fail_count++;
        end
        if (out_root_plus !== exp_r.plus) begin
          $error("root_plus expected %0d actual %0d", exp_r.plus, out_root_plus);
          fail_count++;
        end
        if (out_root_minus !== exp_r.minus) begin
          $error("root_minus expected %0d actual %0d", exp_r.minus, out_root_minus);
          fail_count++;
        end
        if (out_overflow !== exp_r.ov) begin
          $error("overflow expected %0d actual %0d", exp_r.ov, out_overflow);
          fail_count++;
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
      out_ready <= 1'b1;
    end else begin
      run_left <= $urandom_range(0, 6);
      stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void add_item(cmd_t cmd, longint x, longint y, longint z,
                                   longint dx, longint dy, longint dz, longint t);
    hit_item_t it;
    it.cmd = cmd;
    it.px = x[POS_W-1:0]; it.py = y[POS_W-1:0]; it.pz = z[POS_W-1:0];
    it.dx = dx[DIR_W-1:0]; it.dy = dy[DIR_W-1:0]; it.dz = dz[DIR_W-1:0];
    it.stamp = t[STAMP_W-1:0];
    pending_hits = {pending_hits, it};
  endfunction

  function automatic longint rand_dir();
    return longint'($urandom_range(0, 131072)) - 65536;
  endfunction

  function automatic longint rand_full();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint rand_near();
    return longint'($urandom_range(0, 1 << 23)) - (1 << 22);
  endfunction

  // mostly a track followed by plausible hits, with some noise mixed in
  function automatic void add_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      gen_t0 = rand_near();
      add_item(CMD_TRACK, rand_near(), rand_near(), rand_near(),
               rand_dir(), rand_dir(), rand_dir(), gen_t0);
    end else if (pick < 20) begin
      add_item(cmd_t'($urandom_range(0, 1)), rand_full(), rand_full(), rand_full(),
               rand_dir(), rand_dir(), rand_dir(), rand_full());
    end else begin
      add_item(CMD_HIT, rand_near(), rand_near(), rand_near(),
               rand_dir(), rand_dir(), rand_dir(),
               gen_t0 + longint'($urandom_range(0, 1 << 16)) - 1024);
    end
  endfunction

  // register write in setup and access cycles
  task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_INV_INDEX_SQ) k_q16 = longint'(value[INV_W-1:0]);
    else c_q16 = longint'(value[LS_W-1:0]);
  endtask

  // wait until every transaction is taken and all roots are back, then let the core settle
  task automatic drain();
    while (pending_hits.size() > 0 || in_valid || expected_roots.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    repeat (count) add_random_item();
    drain();
  endtask

  initial begin
    trk_x = 0; trk_y = 0; trk_z = 0;
    trk_dx = 0; trk_dy = 0; trk_dz = 0; trk_t = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: hit before any track, degenerate point, typical and extreme geometry
    add_item(CMD_HIT, 0, 0, 0, 0, 0, 0, 0);
    add_item(CMD_TRACK, 0, 0, 0, 0, 0, 65536, 0);
    add_item(CMD_HIT, 0, 0, 0, 0, 0, 0, 0);
    add_item(CMD_HIT, 1000 << 8, 0, 5000 << 8, 0, 0, 0, 20 << 8);
    add_item(CMD_HIT, 2147483647, 2147483647, 2147483647, 65536, 65536, 65536, 2147483647);
    add_item(CMD_HIT, -2147483648, -2147483648, -2147483648, -65536, -65536, -65536,
             -2147483648);
    add_item(CMD_TRACK, -2147483648, 2147483647, 0, -65536, 65536, -65536, -2147483648);
    add_item(CMD_HIT, 2147483647, -2147483648, 0, 0, 0, 0, 2147483647);
    add_item(CMD_TRACK, 2147483647, -2147483648, -2147483648, 65536, -65536, 0, 2147483647);
    add_item(CMD_HIT, -2147483648, 2147483647, 2147483647, 0, 0, 0, -2147483648);
    add_item(CMD_TRACK, 0, 0, 0, 0, 46341, 46341, 0);
    add_item(CMD_HIT, 3000 << 8, 2000 << 8, 8000 << 8, 0, 0, 0, 40 << 8);
    drain();

    // a equal to zero with maximum light speed
    write_reg(REG_INV_INDEX_SQ, 32'd65536);
    write_reg(REG_LIGHT_SPEED, 32'h01FF_FFFF);
    add_item(CMD_HIT, 0, 0, 0, 0, 0, 0, 0);
    add_item(CMD_HIT, 3000 << 8, 2000 << 8, 8000 << 8, 0, 0, 0, 40 << 8);
    add_item(CMD_HIT, -(500 << 8), 0, -(900 << 8), 0, 0, 0, -(10 << 8));
    random_phase(300);

    // tiny a so roots saturate
    write_reg(REG_INV_INDEX_SQ, 32'd65535);
    add_item(CMD_HIT, 3000 << 8, 2000 << 8, 8000 << 8, 0, 0, 0, 40 << 8);
    add_item(CMD_HIT, 2147483647, 0, -2147483648, 0, 0, 0, 2147483647);
    random_phase(300);

    // all-zero registers
    write_reg(REG_INV_INDEX_SQ, 32'd0);
    write_reg(REG_LIGHT_SPEED, 32'd0);
    random_phase(300);

    // back to the water defaults
    write_reg(REG_INV_INDEX_SQ, 32'(INV_RESET));
    write_reg(REG_LIGHT_SPEED, 32'(LS_RESET));
    random_phase(300);

    // random settings, high bits of the register words set too
    write_reg(REG_INV_INDEX_SQ, $urandom());
    write_reg(REG_LIGHT_SPEED, $urandom());
    random_phase(300);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
